// File: sv/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg: shared types and constants for the power-by-squaring block
// Field widths, parameter defaults, sequencer states and the multiplier
// request and response words.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int unsigned BASE_W      = 32;
  localparam int unsigned POWER_W     = 31;
  localparam int unsigned FRAC_BITS_D = 16;
  localparam int unsigned EXP_BITS_D  = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC_WAIT,
    ST_SHIFT,
    ST_SQ_WAIT,
    ST_DONE
  } pbs_state_e;

  typedef struct packed {
    logic              en;
    logic [BASE_W-1:0] op_a;
    logic [BASE_W-1:0] op_b;
  } pbs_mul_req_t;

  typedef struct packed {
    logic              ovf;
    logic [BASE_W-1:0] prod;
  } pbs_mul_rsp_t;

endpackage

// File: sv/pbs_if.sv
// ----------------------------------------------------------------------------
// pbs_if: valid/ready channels of the power-by-squaring block
// Input channel carries base and exponent, output channel the result word.
// ----------------------------------------------------------------------------
interface pbs_in_if import pbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BASE_W-1:0]  base_value;
  logic [POWER_W-1:0] power;

  modport source (output valid, base_value, power, input ready);
  modport sink   (input valid, base_value, power, output ready);
endinterface

interface pbs_out_if import pbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] result_value;
  logic              overflowed;

  modport source (output valid, result_value, overflowed, input ready);
  modport sink   (input valid, result_value, overflowed, output ready);
endinterface

// File: sv/pbs_mul.sv
// ----------------------------------------------------------------------------
// pbs_mul: shared fixed-point multiplier
// Registered 32x32 product, truncated by FRAC_BITS, saturated on overflow.
// ----------------------------------------------------------------------------
module pbs_mul import pbs_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_D
) (
  input  logic         clk_i,
  input  pbs_mul_req_t req_i,
  output pbs_mul_rsp_t rsp_o
);

  logic [2*BASE_W-1:0] full_prod;
  logic [2*BASE_W-1:0] scaled;
  pbs_mul_rsp_t        rsp_d, rsp_q;

  assign full_prod = {{BASE_W{1'b0}}, req_i.op_a} * {{BASE_W{1'b0}}, req_i.op_b};
  assign scaled    = full_prod >> FRAC_BITS;

  always_comb begin
    rsp_d.ovf  = |scaled[2*BASE_W-1:BASE_W];
    rsp_d.prod = rsp_d.ovf ? {BASE_W{1'b1}} : scaled[BASE_W-1:0];
  end

  // hold the product until the next request
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: sv/power_by_squaring_top.sv
// ----------------------------------------------------------------------------
// power_by_squaring_top: unsigned fixed-point power by square-and-multiply
// Raises a Q16.16 base to an integer exponent on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  (sink)   : base_value (unsigned, FRAC_BITS fraction bits) and power.
//   out_o (source) : result_value, same format, and overflowed.
//   One result word per input word, in order.
// Timing:
//   The exponent is scanned LSB first. Each exponent bit passes through
//   check, accumulator product (only for a set bit), shift and square;
//   each product is registered in the multiplier and read in the wait
//   state that follows its request.
//   The block holds in_i.ready low from acceptance until the result word
//   has been taken, so one item is in flight at a time.
// Reset:
//   rst_ni clears the sequencer to idle; no result is pending afterwards.
// Stall:
//   While out_o.ready is low the result word holds on the port and no new
//   input word is accepted.
// Overflow:
//   A product beyond 32 bits forces 0xFFFFFFFF and sets overflowed; a square
//   that overflows only counts when a later set exponent bit would use it.
// ----------------------------------------------------------------------------
module power_by_squaring_top import pbs_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_D,
  parameter int unsigned EXP_BITS  = EXP_BITS_D
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbs_in_if.sink    in_i,
  pbs_out_if.source out_o
);

  // exponent bits that actually take part
  localparam int unsigned EXP_USED = (EXP_BITS < POWER_W) ? EXP_BITS : POWER_W;
  localparam logic [BASE_W-1:0] ONE_FX = BASE_W'(64'd1 << FRAC_BITS);

  pbs_state_e state_q, state_d;

  logic [BASE_W-1:0]   acc_q, acc_d;     // running product
  logic [BASE_W-1:0]   sq_q, sq_d;       // running square of the base
  logic [EXP_USED-1:0] rem_q, rem_d;     // exponent bits still to consume
  logic                sat_q, sat_d;     // result saturated
  logic                sqovf_q, sqovf_d; // current square overflowed

  pbs_mul_req_t mul_req;
  pbs_mul_rsp_t mul_rsp;

  pbs_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // sequencer: next state, datapath updates and multiplier requests
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    sat_d       = sat_q;
    sqovf_d     = sqovf_q;
    mul_req.en   = 1'b0;
    mul_req.op_a = acc_q;
    mul_req.op_b = sq_q;

    case (state_q)
      ST_IDLE: begin
        // load a new item: accumulator starts at 1.0
        if (in_i.valid) begin
          acc_d   = ONE_FX;
          sq_d    = in_i.base_value;
          rem_d   = in_i.power[EXP_USED-1:0];
          sat_d   = 1'b0;
          sqovf_d = 1'b0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rem_q == '0) begin
          state_d = ST_DONE;
        end else if (rem_q[0]) begin
          if (sqovf_q) begin
            // a needed square overflowed: saturate
            sat_d   = 1'b1;
            acc_d   = {BASE_W{1'b1}};
            state_d = ST_DONE;
          end else begin
            mul_req.en = 1'b1;
            state_d    = ST_ACC_WAIT;
          end
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_ACC_WAIT: begin
        acc_d = mul_rsp.prod;
        if (mul_rsp.ovf) begin
          sat_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // drop the consumed bit; square only if bits remain and no square overflowed
        rem_d = rem_q >> 1;
        if ((rem_d != '0) && !sqovf_q) begin
          mul_req.en   = 1'b1;
          mul_req.op_a = sq_q;
          state_d      = ST_SQ_WAIT;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_SQ_WAIT: begin
        sq_d    = mul_rsp.prod;
        sqovf_d = mul_rsp.ovf;
        state_d = ST_CHECK;
      end
      ST_DONE: begin
        // hold the result word until it is taken
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    sat_q   <= sat_d;
    sqovf_q <= sqovf_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = (state_q == ST_DONE);
  assign out_o.result_value = acc_q;
  assign out_o.overflowed   = sat_q;

  // one item in flight: never ready while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input accepted while a result is pending");

  // a saturated result is all ones
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflowed) |-> (out_o.result_value == {BASE_W{1'b1}}))
    else $error("overflowed result is not saturated");

  // an accepted word starts the bit scan
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_CHECK))
    else $error("accepted word did not start the scan");

  // the shift step consumes exactly one exponent bit
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |=> (rem_q == ($past(rem_q) >> 1)))
    else $error("exponent shift lost bits");

endmodule

// File: tb/sv/power_by_squaring_checker.sv
// ----------------------------------------------------------------------------
// power_by_squaring_checker: result predictor and scoreboard
// Watches both channels of the power-by-squaring block, computes base to
// the power for every accepted input word and compares each result word
// in order with the oldest expected one.
// ----------------------------------------------------------------------------
module power_by_squaring_checker import pbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbs_in_if           in_mon,
  pbs_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [BASE_W-1:0] ONE_FX   = 32'h1 << FRAC_BITS_D;
  localparam logic [BASE_W-1:0] WORD_MAX = '1;
  localparam logic [63:0]       EXP_MASK = (64'd1 << EXP_BITS_D) - 64'd1;

  typedef struct packed {
    logic [BASE_W-1:0] result_value;
    logic              overflowed;
  } power_result_t;

  power_result_t expected_results_q[$];

  // Square-and-multiply, LSB first; every product truncated to the fixed format.
  function automatic power_result_t raise_to_power(input logic [BASE_W-1:0]  base,
                                                   input logic [POWER_W-1:0] pwr);
    logic [BASE_W-1:0]  acc;
    logic [BASE_W-1:0]  sq;
    logic [POWER_W-1:0] bits_left;
    logic [63:0]        prod;
    logic               sq_ovf;
    logic               sat;
    power_result_t      res;
    acc       = ONE_FX;
    sq        = base;
    bits_left = pwr & EXP_MASK[POWER_W-1:0];
    sq_ovf    = 1'b0;
    sat       = 1'b0;
    while (bits_left != '0 && !sat) begin
      if (bits_left[0]) begin
        // an overflowed square only hurts once a set bit consumes it
        if (sq_ovf) begin
          sat = 1'b1;
        end else begin
          prod = ({32'b0, acc} * {32'b0, sq}) >> FRAC_BITS_D;
          if (prod[63:32] != '0) sat = 1'b1;
          else acc = prod[31:0];
        end
      end
      if (!sat) begin
        bits_left = bits_left >> 1;
        if (bits_left != '0 && !sq_ovf) begin
          prod = ({32'b0, sq} * {32'b0, sq}) >> FRAC_BITS_D;
          if (prod[63:32] != '0) begin
            sq_ovf = 1'b1;
            sq     = WORD_MAX;
          end else begin
            sq = prod[31:0];
          end
        end
      end
    end
    res.result_value = sat ? WORD_MAX : acc;
    res.overflowed   = sat;
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    power_result_t exp_word;
    if (rst_ni) begin
      // check the result word first: it belongs to an older input word
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result word: result_value %h, overflowed %b",
                   $time, out_mon.result_value, out_mon.overflowed);
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_word = expected_results_q.pop_front();
          if (out_mon.result_value !== exp_word.result_value) begin
            $display("%0t: result_value mismatch: expected %h, actual %h",
                     $time, exp_word.result_value, out_mon.result_value);
            fail_count_o = fail_count_o + 1;
          end
          if (out_mon.overflowed !== exp_word.overflowed) begin
            $display("%0t: overflowed mismatch: expected %b, actual %b",
                     $time, exp_word.overflowed, out_mon.overflowed);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results_q.push_back(raise_to_power(in_mon.base_value, in_mon.power));
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

// File: tb/sv/power_by_squaring_top_test.sv
// ----------------------------------------------------------------------------
// power_by_squaring_top_test: stimulus and verdict for power_by_squaring_top
// Drives directed corner words and then random base/power pairs through
// phases of sender idling and receiver stalling, including one long
// receiver hold-off; the checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module power_by_squaring_top_test import pbs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Worst correct run is roughly 570 words, each up to a full 31-bit exponent,
  // plus sender gaps and receiver stalls; this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  // Drain time after the last expected word: one full 31-bit exponent.
  localparam int unsigned DRAIN_CYCLES  = 130;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_WORDS   = 130;
  localparam int unsigned PRESSURE_WORDS = 30;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;

  // Idle and stall odds in percent, changed per phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  logic        hold_off;

  pbs_in_if  in_bus ();
  pbs_out_if out_bus ();

  power_by_squaring_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  power_by_squaring_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 4 ns clock.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Global timeout; counts every cycle from time zero.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("power_by_squaring_top_test failed");
      $finish;
    end
  end

  // Receiver: drop ready at random, and hold it low for the whole hold-off.
  initial begin
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      out_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering words
  // and the block backs up into its input channel.
  initial begin
    hold_off = 1'b0;
    wait (hold_req === 1'b1);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Offer one word after a random gap and hold it until it is taken.
  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_word(input logic [BASE_W-1:0] base, input logic [POWER_W-1:0] pwr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.base_value <= base;
    in_bus.power      <= pwr;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // Zero, short, random-width and single-bit exponents, and some full width.
  function automatic logic [POWER_W-1:0] pick_power();
    logic [31:0] raw;
    logic [31:0] mask;
    raw  = $urandom;
    mask = (32'h1 << $urandom_range(1, 31)) - 32'h1;
    case ($urandom_range(9))
      0:       return '0;
      1, 2, 3: return POWER_W'($urandom_range(1, 40));
      4, 5, 6: return raw[POWER_W-1:0] & mask[POWER_W-1:0];
      7:       return POWER_W'(1) << $urandom_range(0, POWER_W - 1);
      default: return raw[POWER_W-1:0];
    endcase
  endfunction

  // Bases cluster around 1.0 so long exponents neither saturate nor vanish
  // at once; the rest spans the full word.
  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(9))
      0:       return ($urandom_range(1) != 0) ? '1 : '0;
      1:       return 32'h0001_0000;
      2, 3:    return 32'h0000_FE00 + $urandom_range(0, 32'h400);
      4:       return $urandom_range(0, 32'hFFFF);
      5:       return 32'h1 << $urandom_range(0, 31);
      6:       return $urandom_range(32'h1_0000, 32'h4_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int unsigned words, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (words) send_word(pick_base(), pick_power());
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.base_value = '0;
    in_bus.power      = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_req          = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners, no idling.
    send_word(32'h0000_0000, 31'h0);           // zero power of zero base gives 1.0
    send_word(32'hFFFF_FFFF, 31'h0);           // zero power of the largest base
    send_word(32'h0000_0000, 31'h1);           // zero base, nonzero power
    send_word(32'h0000_0000, 31'h7FFF_FFFF);
    send_word(32'h0001_0000, 31'h7FFF_FFFF);   // 1.0 stays 1.0 over all bits
    send_word(32'hFFFF_FFFF, 31'h1);           // largest base, no square used
    send_word(32'hFFFF_FFFF, 31'h2);           // square overflow that is used
    send_word(32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_word(32'h0100_0000, 31'h1);           // 256.0: its square would overflow but is not formed
    send_word(32'h0100_0000, 31'h2);
    send_word(32'h0100_0000, 31'h4000_0000);   // overflowed square only at the top bit
    send_word(32'h0002_0000, 31'd15);          // 2.0^15 just fits
    send_word(32'h0002_0000, 31'd16);          // 2.0^16 overflows through its square
    send_word(32'h0000_8000, 31'd16);          // 0.5^16 is one LSB
    send_word(32'h0000_8000, 31'd17);          // truncates to zero, no flag
    send_word(32'h0000_0001, 31'h2);           // underflow from the smallest base
    send_word(32'h0000_FFFF, 31'h7FFF_FFFF);   // decays to zero over all bits
    send_word(32'h0001_0001, 31'h7FFF_FFFF);
    send_word(32'h0001_8000, 31'd27);          // 1.5^27, close to the top
    send_word(32'h7FFF_FFFF, 31'h1);
    send_word(32'h8000_0000, 31'h5555_5555);
    send_word(32'h5555_5555, 31'h2AAA_AAAA);

    // Random words across the idle/stall phases.
    run_random(PHASE_WORDS, 0, 0);
    run_random(PHASE_WORDS, 68, 0);
    run_random(PHASE_WORDS, 0, 68);
    run_random(PHASE_WORDS, 19, 19);

    // Pressure: sender never idles while the receiver holds off.
    hold_req = 1'b1;
    run_random(PRESSURE_WORDS, 0, 0);

    in_bus.valid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    // Every expected word must have come back as well.
    if ((fail_count == 0) && (pending == 0)) begin
      $display("power_by_squaring_top_test passed");
    end else begin
      $display("power_by_squaring_top_test failed");
    end
    $finish;
  end

endmodule
